// File: rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
`default_nettype none
package mbps_pkg;

    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = 2;
    localparam int EVQ_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ALL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REP    = 3'd5;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // result stage: first result of an event, or the summary held back behind a report
    typedef enum logic {
        BK_FIRST,
        BK_SUMMARY
    } t_back_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_image;
    } t_in;

    typedef struct packed {
        logic             kind;
        logic [CNT_W-1:0] match_offset;
        logic [CNT_W-1:0] match_count;
        logic             found;
        logic             last_of_run;
    } t_out;

    // one classified byte: an optional match report and an optional summary
    typedef struct packed {
        logic             report;
        logic             eoi;
        logic [CNT_W-1:0] rep_offset;
        logic [CNT_W-1:0] sum_offset;
        logic [CNT_W-1:0] count;
        logic             found;
    } t_event;

endpackage
`default_nettype wire

// File: rtl/mbps_front.sv
// Front end: config registers, byte window, masked compare and match counters.
`default_nettype none
module mbps_front
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 i_push,
    input  wire t_in                  i_item,
    output logic                      o_full,
    input  wire logic [EVQ_CNT_W-1:0] i_q_count,
    output logic                      o_ev_valid,
    output t_event                    o_ev
);

    localparam int WIN_W = MAX_PATTERN * 8;

    logic [PAT_BYTES*8-1:0] r_pattern;
    logic [PAT_BYTES-1:0]   r_care;
    logic [LEN_W-1:0]       r_len;
    logic                   r_report_all;
    logic [CNT_W-1:0]       r_max;

    logic [WIN_W-1:0]       r_window, n_window;
    logic [LEN_W-1:0]       r_fill, n_fill;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_restart;

    logic                   r_b_valid;
    logic                   r_b_eoi;
    logic [OFFSET_BITS-1:0] r_b_pos;

    logic [CNT_W-1:0]       r_count;
    logic                   r_found;
    logic [CNT_W-1:0]       r_first;

    logic                   accept;
    logic [EVQ_CNT_W:0]     pending;
    logic [MAX_PATTERN-1:0] age_ok;
    logic                   len_ok;
    logic                   match;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS+CNT_W-1:0] start_ext;
    logic [CNT_W-1:0]       start32;
    logic [CNT_W-1:0]       count_upd;
    logic                   found_upd;
    logic [CNT_W-1:0]       first_upd;
    logic                   report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern    <= '0;
            r_care       <= '0;
            r_len        <= '0;
            r_report_all <= 1'b1;
            r_max        <= COUNT_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAT_LO:     r_pattern[63:0]   <= i_cfg_data;
                CFG_PAT_HI:     r_pattern[127:64] <= i_cfg_data;
                CFG_CARE_MASK:  r_care            <= i_cfg_data[PAT_BYTES-1:0];
                CFG_PAT_LEN:    r_len             <= i_cfg_data[LEN_W-1:0];
                CFG_REPORT_ALL: r_report_all      <= i_cfg_data[0];
                CFG_MAX_REP:    r_max             <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // slots in flight: queued events plus the one in the compare stage
    assign pending = {1'b0, i_q_count} + {{EVQ_CNT_W{1'b0}}, r_b_valid};
    assign o_full  = pending >= (EVQ_CNT_W+1)'(EVQ_DEPTH);
    assign accept  = i_push && !o_full;

    always_comb begin
        logic [WIN_W-1:0]       base_win;
        logic [LEN_W-1:0]       base_fill;
        logic [OFFSET_BITS-1:0] base_pos;
        base_win  = r_restart ? '0 : r_window;
        base_fill = r_restart ? '0 : r_fill;
        base_pos  = r_restart ? '0 : r_pos;
        n_window  = WIN_W'({base_win, i_item.data_byte});
        n_fill    = (base_fill < LEN_W'(MAX_PATTERN)) ? base_fill + 5'd1 : base_fill;
        n_pos     = base_pos;
    end

    // stage A: shift the byte in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= '0;
            r_fill    <= '0;
            r_pos     <= '0;
            r_restart <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
            if (accept) begin
                r_window  <= n_window;
                r_fill    <= n_fill;
                r_pos     <= n_pos + OFFSET_BITS'(1);
                r_restart <= i_item.end_of_image;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_eoi <= i_item.end_of_image;
            r_b_pos <= n_pos;
        end
    end

    // stage B: masked compare, newest byte at age 0
    for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_age
        logic [LEN_W-1:0] idx5;
        logic [3:0]       idx;
        assign idx5     = r_len - LEN_W'(a) - 5'd1;
        assign idx      = idx5[3:0];
        assign age_ok[a] = (LEN_W'(a) >= r_len) || !r_care[idx]
                           || (r_window[8*a +: 8] == r_pattern[8*idx +: 8]);
    end

    assign len_ok = (r_len != '0) && (r_len <= LEN_W'(MAX_PATTERN)) && (r_fill >= r_len);
    assign match  = r_b_valid && len_ok && (&age_ok) && (r_report_all || !r_found);

    assign start     = r_b_pos - OFFSET_BITS'(r_len - 5'd1);
    assign start_ext = {{CNT_W{1'b0}}, start};
    assign start32   = start_ext[CNT_W-1:0];

    always_comb begin
        count_upd = r_count;
        found_upd = r_found;
        first_upd = r_first;
        if (match) begin
            if (r_count != COUNT_MAX) begin
                count_upd = r_count + 32'd1;
            end
            found_upd = 1'b1;
            if (!r_found) begin
                first_upd = start32;
            end
        end
    end

    assign report = match && (count_upd <= r_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
            r_first <= '0;
        end else if (r_b_valid) begin
            if (r_b_eoi) begin
                r_count <= '0;
                r_found <= 1'b0;
                r_first <= '0;
            end else begin
                r_count <= count_upd;
                r_found <= found_upd;
                r_first <= first_upd;
            end
        end
    end

    assign o_ev_valid    = r_b_valid && (report || r_b_eoi);
    assign o_ev.report     = report;
    assign o_ev.eoi        = r_b_eoi;
    assign o_ev.rep_offset = start32;
    assign o_ev.sum_offset = found_upd ? first_upd : '0;
    assign o_ev.count      = count_upd;
    assign o_ev.found      = found_upd;

endmodule
`default_nettype wire

// File: rtl/mbps_evq.sv
// Short event queue between the classifier and the result stage.
`default_nettype none
module mbps_evq
    import mbps_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire t_event               i_wr_data,
    input  wire logic                 i_rd,
    output t_event                    o_rd_data,
    output logic                      o_nonempty,
    output logic [EVQ_CNT_W-1:0]      o_count
);

    t_event                 r_mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]   r_wr_ptr;
    logic [EVQ_PTR_W-1:0]   r_rd_ptr;
    logic [EVQ_CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 3'd1;
                2'b01:   r_count <= r_count - 3'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rd_data  = r_mem[r_rd_ptr];
    assign o_nonempty = r_count != '0;
    assign o_count    = r_count;

endmodule
`default_nettype wire

// File: rtl/mbps_back.sv
// Back end: expands events into report and summary results in an output register.
`default_nettype none
module mbps_back
    import mbps_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_ev_nonempty,
    input  wire t_event i_ev,
    output logic        o_ev_rd,
    input  wire logic   pop,
    output logic        empty,
    output t_out        o_result
);

    t_back_state r_phase, n_phase;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;
    logic        load;

    assign load = !r_out_valid || pop;

    always_comb begin
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_ev_rd     = 1'b0;
        if (load) begin
            n_out_valid = i_ev_nonempty;
            if (i_ev_nonempty) begin
                if (r_phase == BK_FIRST && i_ev.report) begin
                    n_out.kind         = KIND_REPORT;
                    n_out.match_offset = i_ev.rep_offset;
                    n_out.match_count  = i_ev.count;
                    n_out.found        = 1'b1;
                    n_out.last_of_run  = !i_ev.eoi;
                    if (i_ev.eoi) begin
                        n_phase = BK_SUMMARY;
                    end else begin
                        o_ev_rd = 1'b1;
                    end
                end else begin
                    n_out.kind         = KIND_SUMMARY;
                    n_out.match_offset = i_ev.sum_offset;
                    n_out.match_count  = i_ev.count;
                    n_out.found        = i_ev.found;
                    n_out.last_of_run  = 1'b1;
                    n_phase            = BK_FIRST;
                    o_ev_rd            = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= BK_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

// File: rtl/masked_byte_pattern_scanner_top.sv
// Masked byte pattern scanner: top level tying classifier, event queue and result stage.
//
// Takes one image byte per cycle through a push/full queue port and reports
// matches of a masked pattern of up to MAX_PATTERN bytes against the newest
// bytes of the image, overlapping matches included. An accepted byte is
// registered into the compare stage, its event is written into a four-entry
// queue, and the output register loads the result from there, after which
// it can be popped. Input rate is one byte per cycle while results are
// drained; full rises when the queue and the compare stage together hold
// four requests. A byte that yields both a match report and the end-of-image
// summary gives two results on the result port, the report before the
// summary. Configuration writes are always ready and take effect at once,
// so they must be issued only while no image byte is in flight.
`default_nettype none
module masked_byte_pattern_scanner_top
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire t_in                  i_item,
    output logic                      empty,
    input  wire logic                 pop,
    output t_out                      o_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic                 ev_valid;
    t_event               ev_wr;
    t_event               ev_rd;
    logic                 ev_rd_en;
    logic                 ev_nonempty;
    logic [EVQ_CNT_W-1:0] ev_count;

    assign o_cfg_ready = 1'b1;

    mbps_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_q_count   (ev_count),
        .o_ev_valid  (ev_valid),
        .o_ev        (ev_wr)
    );

    mbps_evq u_evq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (ev_valid),
        .i_wr_data  (ev_wr),
        .i_rd       (ev_rd_en),
        .o_rd_data  (ev_rd),
        .o_nonempty (ev_nonempty),
        .o_count    (ev_count)
    );

    mbps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ev_nonempty (ev_nonempty),
        .i_ev          (ev_rd),
        .o_ev_rd       (ev_rd_en),
        .pop           (pop),
        .empty         (empty),
        .o_result      (o_result)
    );

endmodule
`default_nettype wire

// File: rtl/mbps_checker.sv
// Port-level checker for the scanner and its bind to the top level.
`default_nettype none
module mbps_checker
    import mbps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic empty,
    input  wire logic pop,
    input  wire t_out o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result port not empty after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_SUMMARY) |-> o_result.last_of_run)
        else $error("summary without last_of_run");

    a_report_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_REPORT) |->
        (o_result.found && o_result.match_count != '0))
        else $error("match report without found or count");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_SUMMARY && !o_result.found) |->
        (o_result.match_offset == '0 && o_result.match_count == '0))
        else $error("summary with no match has nonzero fields");

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
`default_nettype wire
